@@ design/magnetometer_hard_iron_correction_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the hard-iron correction unit
// Checks sampled on clock, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef MAGNETOMETER_HARD_IRON_CORRECTION_UNIT_ASSERT_SVH
`define MAGNETOMETER_HARD_IRON_CORRECTION_UNIT_ASSERT_SVH

// same-cycle implication
`define HICU_ASSERT_NOW(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("hicu: same-cycle check failed");

// next-cycle implication
`define HICU_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("hicu: next-cycle check failed");

`endif

@@ design/hicu_pkg.sv @@
// ----------------------------------------------------------------------------
// hicu_pkg
// Shared widths, constants and types of the hard-iron correction unit.
// ----------------------------------------------------------------------------
`default_nettype none

package hicu_pkg;

   localparam int NUM_AXES     = 3;
   localparam int RAW_W        = 16;
   localparam int FIELD_W      = 33;
   localparam int ADJ_W        = 8;
   localparam int CSR_DATA_W   = 8;
   localparam int CSR_INDEX_W  = 3;

   // scale in hundredths of uT per count
   localparam int SCALE_W      = 6;
   localparam logic [SCALE_W-1:0] SCALE_FINE   = 6'd15;
   localparam logic [SCALE_W-1:0] SCALE_COARSE = 6'd60;
   localparam int GAIN_W       = ADJ_W + 1;
   localparam logic [GAIN_W-1:0] GAIN_OFFSET  = 9'd128;
   localparam int RAW_SHIFT    = 9;

   localparam int SUM_W        = RAW_W + 1;
   localparam int RAWSC_W      = RAW_W + SCALE_W + 1;
   localparam int SUMSC_W      = SUM_W + SCALE_W + 1;
   localparam int BIASP_W      = SUMSC_W + GAIN_W + 1;

   // calibration run lengths
   localparam int FAST_SAMPLES = 1000;
   localparam int SLOW_SAMPLES = 80;
   localparam int RUN_MAX      = (FAST_SAMPLES > SLOW_SAMPLES) ? FAST_SAMPLES : SLOW_SAMPLES;
   localparam int CNT_W        = $clog2(RUN_MAX + 1);
   localparam logic [CNT_W-1:0] RUN_FAST_LEN = CNT_W'(RUN_MAX);
   localparam logic [CNT_W-1:0] RUN_SLOW_LEN = CNT_W'(SLOW_SAMPLES);

   typedef enum logic [1:0] {
      STATUS_OK           = 2'd0,
      STATUS_WRONG_DEVICE = 2'd1,
      STATUS_NOT_READY    = 2'd2,
      STATUS_OVERFLOW     = 2'd3
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SIXTEEN_BIT = 3'd0,
      CSR_FAST_RATE   = 3'd1,
      CSR_ID_VALID    = 3'd2,
      CSR_ADJUST_X    = 3'd3,
      CSR_ADJUST_Y    = 3'd4,
      CSR_ADJUST_Z    = 3'd5
   } csr_index_type;

   // per-item commands from the sequencer to every lane
   typedef struct packed {
      logic take;       // sample accepted, replace last raw
      logic cal;        // calibration step: update min/max
      logic restart;    // first sample of a run
      logic bias_load;  // run ended, load new bias
   } lane_ctrl_type;

endpackage

`default_nettype wire

@@ design/hicu_req_if.sv @@
// ----------------------------------------------------------------------------
// hicu_req_if
// Sample channel: valid/ready handshake with one three-axis sample.
// ----------------------------------------------------------------------------
`default_nettype none

interface hicu_req_if;
   logic                                valid;
   logic                                ready;
   logic                                mode;
   logic                                ready_req;
   logic                                overflowed;
   logic signed [hicu_pkg::RAW_W-1:0]   raw_x;
   logic signed [hicu_pkg::RAW_W-1:0]   raw_y;
   logic signed [hicu_pkg::RAW_W-1:0]   raw_z;

   modport source (output valid, mode, ready_req, overflowed, raw_x, raw_y, raw_z,
                   input ready);
   modport sink   (input valid, mode, ready_req, overflowed, raw_x, raw_y, raw_z,
                   output ready);
endinterface

`default_nettype wire

@@ design/hicu_rsp_if.sv @@
// ----------------------------------------------------------------------------
// hicu_rsp_if
// Result channel: valid/ready handshake with corrected field and status.
// ----------------------------------------------------------------------------
`default_nettype none

interface hicu_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [hicu_pkg::FIELD_W-1:0] field_x;
   logic signed [hicu_pkg::FIELD_W-1:0] field_y;
   logic signed [hicu_pkg::FIELD_W-1:0] field_z;
   logic [1:0]                          status;
   logic                                calibration_done;

   modport source (output valid, field_x, field_y, field_z, status, calibration_done,
                   input ready);
   modport sink   (input valid, field_x, field_y, field_z, status, calibration_done,
                   output ready);
endinterface

`default_nettype wire

@@ design/hicu_lane.sv @@
// ----------------------------------------------------------------------------
// hicu_lane
// One axis: last sample, min/max tracking, bias and corrected field.
// ----------------------------------------------------------------------------
`default_nettype none

module hicu_lane (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire hicu_pkg::lane_ctrl_type              ctrl,
   input  wire logic signed [hicu_pkg::RAW_W-1:0]    raw,
   input  wire logic [hicu_pkg::ADJ_W-1:0]           adjust,
   input  wire logic [hicu_pkg::SCALE_W-1:0]         scale,
   output logic signed [hicu_pkg::FIELD_W-1:0]       field
);

   logic signed [hicu_pkg::RAW_W-1:0]   last_raw_ff, last_raw_in;
   logic signed [hicu_pkg::RAW_W-1:0]   min_ff, min_in;
   logic signed [hicu_pkg::RAW_W-1:0]   max_ff, max_in;
   logic signed [hicu_pkg::FIELD_W-1:0] bias_ff, bias_in;
   logic signed [hicu_pkg::RAWSC_W-1:0] raw_sc_ff, raw_sc_in;
   logic signed [hicu_pkg::SUMSC_W-1:0] sum_sc_ff, sum_sc_in;

   logic signed [hicu_pkg::RAW_W-1:0]   run_min, run_max;
   logic signed [hicu_pkg::SUM_W-1:0]   sum;
   logic signed [hicu_pkg::SCALE_W:0]   scale_s;
   logic [hicu_pkg::GAIN_W-1:0]         gain;
   logic signed [hicu_pkg::GAIN_W:0]    gain_s;
   logic signed [hicu_pkg::BIASP_W-1:0] bias_prod;

   assign scale_s = {1'b0, scale};
   assign gain    = {1'b0, adjust} + hicu_pkg::GAIN_OFFSET;
   assign gain_s  = {1'b0, gain};

   // sample and extremes (accept cycle)
   always_comb begin
      last_raw_in = ctrl.take ? raw : last_raw_ff;
      run_min     = ctrl.restart ? '0 : min_ff;
      run_max     = ctrl.restart ? hicu_pkg::RAW_W'(1) : max_ff;
      min_in      = min_ff;
      max_in      = max_ff;
      if (ctrl.cal) begin
         min_in = (last_raw_in < run_min) ? last_raw_in : run_min;
         max_in = (last_raw_in > run_max) ? last_raw_in : run_max;
      end
   end

   // first multiply stage: scale raw and min+max
   assign sum       = {min_ff[hicu_pkg::RAW_W-1], min_ff} + {max_ff[hicu_pkg::RAW_W-1], max_ff};
   assign raw_sc_in = last_raw_ff * scale_s;
   assign sum_sc_in = sum * scale_s;

   // second multiply stage: sensitivity gain on the bias
   assign bias_prod = sum_sc_ff * gain_s;
   assign bias_in   = ctrl.bias_load ? bias_prod[hicu_pkg::FIELD_W-1:0] : bias_ff;

   // raw * scale * 512 - bias
   assign field = {raw_sc_ff[hicu_pkg::RAWSC_W-1], raw_sc_ff, hicu_pkg::RAW_SHIFT'(0)}
                  - bias_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_raw_ff <= '0;
         min_ff      <= '0;
         max_ff      <= hicu_pkg::RAW_W'(1);
         bias_ff     <= '0;
      end else begin
         last_raw_ff <= last_raw_in;
         min_ff      <= min_in;
         max_ff      <= max_in;
         bias_ff     <= bias_in;
      end
   end

   always_ff @(posedge clock) begin
      raw_sc_ff <= raw_sc_in;
      sum_sc_ff <= sum_sc_in;
   end

endmodule

`default_nettype wire

@@ design/magnetometer_hard_iron_correction_unit.sv @@
// ----------------------------------------------------------------------------
// magnetometer_hard_iron_correction_unit
// Three-axis hard-iron correction with min/max calibration runs.
// ----------------------------------------------------------------------------
// Each item is one magnetometer sample; each gives exactly one result item
// with the corrected field per axis in units of 1/51200 uT and a status.
// An item passes the steps accept (sample select, min/max update, run count),
// scale multiply, bias multiply, and the final subtract into the result
// register. A new item is taken only once the sequencer is back in idle;
// the result register lets the next item enter while a result still waits,
// and the sequencer holds in its last step only if the previous result has
// not been taken. The three axes run in three identical lanes; the result
// register merges them with the status and the end-of-run flag. Calibration
// runs last 1000 calibration items in fast mode and 80 otherwise. The user
// must write configuration through the csr port only while no item is in
// flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

`include "magnetometer_hard_iron_correction_unit_assert.svh"

module magnetometer_hard_iron_correction_unit (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   hicu_req_if.sink                                   req_chan,
   hicu_rsp_if.source                                 rsp_chan,
   input  wire logic                                  csr_write_en,
   input  wire logic [hicu_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [hicu_pkg::CSR_DATA_W-1:0]       csr_write_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCALE,
      ST_BIAS,
      ST_DIFF
   } state_type;

   // configuration registers
   logic                       sixteen_bit_ff;
   logic                       fast_rate_ff;
   logic                       id_valid_ff;
   logic [hicu_pkg::ADJ_W-1:0] adjust_ff [hicu_pkg::NUM_AXES];

   // sequencer state and result register
   state_type                           state_ff, state_in;
   logic [hicu_pkg::CNT_W-1:0]          count_ff, count_in;
   hicu_pkg::status_type                status_ff, status_in;
   logic                                done_ff, done_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic signed [hicu_pkg::FIELD_W-1:0] rsp_field_ff [hicu_pkg::NUM_AXES];
   logic signed [hicu_pkg::FIELD_W-1:0] rsp_field_in [hicu_pkg::NUM_AXES];
   hicu_pkg::status_type                rsp_status_ff, rsp_status_in;
   logic                                rsp_done_ff, rsp_done_in;

   logic                                accept;
   logic                                load_rsp;
   logic                                cal;
   logic [hicu_pkg::CNT_W-1:0]          count_next;
   logic [hicu_pkg::CNT_W-1:0]          run_len;
   logic [hicu_pkg::SCALE_W-1:0]        scale;
   hicu_pkg::status_type                item_status;
   hicu_pkg::lane_ctrl_type             lane_ctrl;
   logic signed [hicu_pkg::RAW_W-1:0]   lane_raw   [hicu_pkg::NUM_AXES];
   logic signed [hicu_pkg::FIELD_W-1:0] lane_field [hicu_pkg::NUM_AXES];

   // ---------------- configuration port ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         sixteen_bit_ff <= 1'b1;
         fast_rate_ff   <= 1'b1;
         id_valid_ff    <= 1'b1;
         for (int a = 0; a < hicu_pkg::NUM_AXES; a++) begin
            adjust_ff[a] <= hicu_pkg::ADJ_W'(128);
         end
      end else if (csr_write_en) begin
         unique case (hicu_pkg::csr_index_type'(csr_index))
            hicu_pkg::CSR_SIXTEEN_BIT: sixteen_bit_ff <= csr_write_data[0];
            hicu_pkg::CSR_FAST_RATE:   fast_rate_ff   <= csr_write_data[0];
            hicu_pkg::CSR_ID_VALID:    id_valid_ff    <= csr_write_data[0];
            hicu_pkg::CSR_ADJUST_X:    adjust_ff[0]   <= csr_write_data[hicu_pkg::ADJ_W-1:0];
            hicu_pkg::CSR_ADJUST_Y:    adjust_ff[1]   <= csr_write_data[hicu_pkg::ADJ_W-1:0];
            hicu_pkg::CSR_ADJUST_Z:    adjust_ff[2]   <= csr_write_data[hicu_pkg::ADJ_W-1:0];
            default: ;  // unmapped index, ignored
         endcase
      end
   end

   assign scale   = sixteen_bit_ff ? hicu_pkg::SCALE_FINE : hicu_pkg::SCALE_COARSE;
   assign run_len = fast_rate_ff ? hicu_pkg::RUN_FAST_LEN : hicu_pkg::RUN_SLOW_LEN;

   // ---------------- accept step ----------------
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;

   // wrong device beats not ready, not ready beats overflow
   always_comb begin
      priority if (!id_valid_ff)         item_status = hicu_pkg::STATUS_WRONG_DEVICE;
      else if (!req_chan.ready_req)      item_status = hicu_pkg::STATUS_NOT_READY;
      else if (req_chan.overflowed)      item_status = hicu_pkg::STATUS_OVERFLOW;
      else                               item_status = hicu_pkg::STATUS_OK;
   end

   // a calibration item with a valid id always counts, even if the sample is reused
   assign cal        = accept && req_chan.mode && id_valid_ff;
   assign count_next = count_ff + hicu_pkg::CNT_W'(1);

   always_comb begin
      lane_ctrl.take      = accept && (item_status == hicu_pkg::STATUS_OK);
      lane_ctrl.cal       = cal;
      lane_ctrl.restart   = cal && (count_ff == '0);
      lane_ctrl.bias_load = (state_ff == ST_BIAS) && done_ff;
   end

   assign lane_raw[0] = req_chan.raw_x;
   assign lane_raw[1] = req_chan.raw_y;
   assign lane_raw[2] = req_chan.raw_z;

   // ---------------- axis lanes ----------------
   for (genvar a = 0; a < hicu_pkg::NUM_AXES; a++) begin : g_lane
      hicu_lane u_lane (
         .clock  (clock),
         .reset  (reset),
         .ctrl   (lane_ctrl),
         .raw    (lane_raw[a]),
         .adjust (adjust_ff[a]),
         .scale  (scale),
         .field  (lane_field[a])
      );
   end

   // ---------------- sequencer and merge into result register ----------------
   assign load_rsp = (state_ff == ST_DIFF) && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      status_in     = status_ff;
      done_in       = done_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_done_in   = rsp_done_ff;
      for (int a = 0; a < hicu_pkg::NUM_AXES; a++) begin
         rsp_field_in[a] = rsp_field_ff[a];
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               status_in = item_status;
               done_in   = 1'b0;
               if (cal) begin
                  // run ends once the count reaches the current length
                  if (count_next >= run_len) begin
                     count_in = '0;
                     done_in  = 1'b1;
                  end else begin
                     count_in = count_next;
                  end
               end
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: state_in = ST_BIAS;
         ST_BIAS:  state_in = ST_DIFF;
         ST_DIFF: begin
            if (load_rsp) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_done_in   = done_ff;
               for (int a = 0; a < hicu_pkg::NUM_AXES; a++) begin
                  rsp_field_in[a] = lane_field[a];
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      status_ff     <= status_in;
      done_ff       <= done_in;
      rsp_status_ff <= rsp_status_in;
      rsp_done_ff   <= rsp_done_in;
      for (int a = 0; a < hicu_pkg::NUM_AXES; a++) begin
         rsp_field_ff[a] <= rsp_field_in[a];
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.field_x          = rsp_field_ff[0];
   assign rsp_chan.field_y          = rsp_field_ff[1];
   assign rsp_chan.field_z          = rsp_field_ff[2];
   assign rsp_chan.status           = rsp_status_ff;
   assign rsp_chan.calibration_done = rsp_done_ff;

   // ---------------- assertions ----------------
   `HICU_ASSERT_NEXT(a_accept_starts_item, accept, state_ff == ST_SCALE)
   `HICU_ASSERT_NOW(a_count_in_range, 1'b1, count_ff < hicu_pkg::CNT_W'(hicu_pkg::RUN_MAX))
   `HICU_ASSERT_NEXT(a_rsp_only_from_diff, !rsp_valid_ff && state_ff != ST_DIFF, !rsp_valid_ff)
   `HICU_ASSERT_NOW(a_done_needs_device, rsp_valid_ff && rsp_done_ff, rsp_status_ff != hicu_pkg::STATUS_WRONG_DEVICE)

endmodule

`default_nettype wire
